// ===== design/ktir_pkg.sv =====
// ----------------------------------------------------------------------------
// ktir_pkg
// Shared types and codes for the keyed table insert/remove core.
// ----------------------------------------------------------------------------
package ktir_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Request opcodes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned COUNT_W = 5;

endpackage

// ===== design/ktir_ram.sv =====
// ----------------------------------------------------------------------------
// ktir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ktir_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/keyed_table_insert_remove_core.sv =====
// ----------------------------------------------------------------------------
// keyed_table_insert_remove_core
// Bounded table of unique keys with payloads, packed from slot 0.
// A full insert, or any request on an empty table, gives its result in the
//   cycle after start. Otherwise a key scan, one key RAM read per cycle
//   (n = entries held): a duplicate ends the scan at its slot; a miss reads
//   all n slots; a remove hit then shifts every later slot down by one.
// One request at a time; busy is high only while a scan or compaction runs.
// The receiver cannot stall: out_valid is a one-cycle strobe.
// Reset (synchronous, rst_n low) empties the table; RAM contents are kept
//   but never read beyond the entry count.
// ----------------------------------------------------------------------------
module keyed_table_insert_remove_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic signed [31:0] in_key,
  input  logic        [31:0] in_payload,
  // result channel
  output logic               out_valid,
  output logic        [2:0]  out_status,
  output logic        [4:0]  out_entry_count
);

  localparam int unsigned AW = $clog2(CAPACITY);      // slot address width
  localparam int unsigned CW = $clog2(CAPACITY + 1);  // entry count width

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT
  } state_t;

  // Registers
  state_t                       state_r,     state_nxt;
  logic                         cmd_r,       cmd_nxt;
  logic [ktir_pkg::KEY_W-1:0]   key_r,       key_nxt;
  logic [ktir_pkg::PAY_W-1:0]   pay_r,       pay_nxt;
  logic [CW-1:0]                count_r,     count_nxt;
  // Read pointer: scan index in search, source slot in compaction
  logic [CW-1:0]                rd_idx_r,    rd_idx_nxt;
  // Slot whose read data arrives this cycle (compare in search, dest in shift)
  logic                         pend_vld_r,  pend_vld_nxt;
  logic [AW-1:0]                pend_idx_r,  pend_idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  ktir_pkg::status_t            status_r,    status_nxt;

  // RAM ports
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [ktir_pkg::KEY_W-1:0]   key_wdata,   key_rdata;
  logic [ktir_pkg::PAY_W-1:0]   pay_wdata,   pay_rdata;

  logic                         issue;
  logic                         hit;
  logic [CW-1:0]                rd_idx_m1;
  logic [CW+4:0]                count_ext;

  ktir_ram #(
    .WIDTH (ktir_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_wdata),
    .raddr (ram_raddr),
    .rdata (key_rdata)
  );

  ktir_ram #(
    .WIDTH (ktir_pkg::PAY_W),
    .DEPTH (CAPACITY)
  ) u_pay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (pay_wdata),
    .raddr (ram_raddr),
    .rdata (pay_rdata)
  );

  // Another slot remains to be read while the pointer is below the count
  assign issue     = (rd_idx_r < count_r);
  assign hit       = pend_vld_r && (key_rdata == key_r);
  assign rd_idx_m1 = rd_idx_r - CW'(1);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    pend_vld_nxt  = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;

    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_raddr = rd_idx_r[AW-1:0];
    key_wdata = key_r;
    pay_wdata = pay_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_cmd;
          key_nxt = $unsigned(in_key);
          pay_nxt = in_payload;
          if (in_cmd == ktir_pkg::CMD_INSERT && count_r == CW'(CAPACITY)) begin
            // Full check wins over the duplicate check
            out_valid_nxt = 1'b1;
            status_nxt    = ktir_pkg::ST_FULL;
          end else if (count_r == '0) begin
            // Empty table: nothing to search
            out_valid_nxt = 1'b1;
            if (in_cmd == ktir_pkg::CMD_INSERT) begin
              ram_we     = 1'b1;
              key_wdata  = $unsigned(in_key);
              pay_wdata  = in_payload;
              count_nxt  = count_r + CW'(1);
              status_nxt = ktir_pkg::ST_INSERTED;
            end else begin
              status_nxt = ktir_pkg::ST_NOT_FOUND;
            end
          end else begin
            state_nxt  = S_SEARCH;
            rd_idx_nxt = '0;
          end
        end
      end

      S_SEARCH: begin
        // Pipelined scan: issue slot rd_idx, compare the slot read last cycle
        pend_vld_nxt = issue;
        pend_idx_nxt = rd_idx_r[AW-1:0];
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        if (hit) begin
          pend_vld_nxt = 1'b0;
          if (cmd_r == ktir_pkg::CMD_INSERT) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            status_nxt    = ktir_pkg::ST_DUPLICATE;
          end else begin
            // Compaction starts reading the slot after the hit
            state_nxt  = S_SHIFT;
            rd_idx_nxt = CW'(pend_idx_r) + CW'(1);
          end
        end else if (!issue && !pend_vld_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (cmd_r == ktir_pkg::CMD_INSERT) begin
            ram_we     = 1'b1;
            count_nxt  = count_r + CW'(1);
            status_nxt = ktir_pkg::ST_INSERTED;
          end else begin
            status_nxt = ktir_pkg::ST_NOT_FOUND;
          end
        end
      end

      S_SHIFT: begin
        // Read slot j+1 and write it to slot j in the next cycle
        pend_vld_nxt = issue;
        pend_idx_nxt = rd_idx_m1[AW-1:0];
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        if (pend_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_r;
          key_wdata = key_rdata;
          pay_wdata = pay_rdata;
        end
        if (!issue && !pend_vld_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          count_nxt     = count_r - CW'(1);
          status_nxt    = ktir_pkg::ST_REMOVED;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    status_r   <= status_nxt;
  end

  // Count is reported modulo 32
  assign count_ext       = {5'b0, count_r};
  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_count = count_ext[4:0];

endmodule
